// File: design/pbz_pkg.sv
// shared constants, types and codes for the piecewise cubic bezier solver
`timescale 1ns / 1ps
package pbz_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int FRAC_BITS    = 16;
	localparam int NEWTON_STEPS = 8;

	localparam int COORD_W     = 20;
	localparam int CNT_W       = 5;
	localparam int SEG_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int STORE_DEPTH = MAX_SEGMENTS * 4;
	localparam int ADDR_W      = SEG_W + 2;
	localparam int PT_W        = 2 * COORD_W;

	localparam int ONE_Q        = 1 << FRAC_BITS;
	localparam int T_LIMIT      = 8 << FRAC_BITS;
	localparam int EPS_Q        = (ONE_Q + 999) / 1000;
	localparam int DERIV_MIN    = (ONE_Q + 999999) / 1000000;
	localparam int BISECT_STEPS = FRAC_BITS + 2;

	// widths of the datapath
	localparam int TW     = FRAC_BITS + 5;
	localparam int CW     = COORD_W + 6;
	localparam int ACC_W  = 2 * COORD_W - 4;
	localparam int E_W    = ACC_W + 1;
	localparam int QBITS  = FRAC_BITS + 6;
	localparam int NUM_W  = E_W + FRAC_BITS;
	localparam int REM_W  = ACC_W + QBITS;
	localparam int NI_W   = $clog2(NEWTON_STEPS + 1);
	localparam int BI_W   = $clog2(BISECT_STEPS + 1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NOCONV  = 2'd2
	} status_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [ACC_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QBITS-1:0] quo;
	} div_rsp_t;

endpackage

// File: design/pbz_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pbz_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/pbz_mac.sv
// shared multiply, floor shift and add unit with result register
`timescale 1ns / 1ps
module pbz_mac (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [pbz_pkg::ACC_W-1:0] op_a,
	input  logic signed [pbz_pkg::TW-1:0]    op_t,
	input  logic signed [pbz_pkg::ACC_W-1:0] addend,
	output logic signed [pbz_pkg::ACC_W-1:0] acc
);
	import pbz_pkg::*;

	logic signed [ACC_W+TW-1:0] prod;
	logic signed [ACC_W+TW-1:0] prod_sh;
	logic signed [ACC_W-1:0]    res;

	assign prod    = op_a * op_t;
	// arithmetic shift rounds toward minus infinity
	assign prod_sh = prod >>> FRAC_BITS;
	assign res     = $signed(prod_sh[ACC_W-1:0]) + addend;

	always_ff @(posedge clk) begin
		if (en) begin
			acc <= res;
		end
	end
endmodule

// File: design/pbz_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pbz_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pbz_pkg::div_req_t req,
	output pbz_pkg::div_rsp_t rsp
);
	import pbz_pkg::*;

	localparam int CNTW = $clog2(QBITS);

	logic             busy_q;
	logic             done_q;
	logic [CNTW-1:0]  cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [QBITS-1:0] quo_q;
	logic             ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QBITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= REM_W'(req.num);
			dsh_q <= REM_W'(req.den) << (QBITS - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QBITS-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		assert property (disable iff (!arst_n) req.start |=> busy_q)
			else $error("divider did not start");
		assert property (disable iff (!arst_n) done_q |-> !busy_q)
			else $error("divider done while busy");
		assert property (disable iff (!arst_n) busy_q |-> !req.start)
			else $error("divider restarted while busy");
	end
endmodule

// File: design/piecewise_cubic_bezier_y_from_x_core.sv
// top level: point store, segment search and newton / bisection sequencer
//
//  channel | signals                                      | dir | flow
//  in      | in_valid in_stall cmd segment_index          | in  | valid/stall
//          | point_index point_x point_y query_x          |     |
//  out     | out_valid out_stall y_value status           | out | valid/stall
//  cfg     | cfg_we cfg_data (segment_count)              | in  | write only
//
// a write beat leaves the sequencer idle; an evaluate beat checks the table, searches the segments,
// loads four points, then runs newton steps that wait on the divider, bisection steps if needed and
// the evaluation of y, paced by the shared multiplier and the serial divider
// in_stall is high from an evaluate beat until its result is placed in the output register
// the output register holds a result under out_stall while the next beat is taken
// reset clears the sequencer, the output valid and segment_count; the point store is not cleared
`timescale 1ns / 1ps
module piecewise_cubic_bezier_y_from_x_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pbz_pkg::CNT_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [3:0]                          segment_index,
	input  logic [1:0]                          point_index,
	input  logic signed [pbz_pkg::COORD_W-1:0]  point_x,
	input  logic signed [pbz_pkg::COORD_W-1:0]  point_y,
	input  logic signed [pbz_pkg::COORD_W-1:0]  query_x,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pbz_pkg::COORD_W-1:0]  y_value,
	output logic [1:0]                          status
);
	import pbz_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE   = 19'h00001,
		S_CHK_A  = 19'h00002,
		S_CHK_B  = 19'h00004,
		S_CHK_C  = 19'h00008,
		S_SRCH_A = 19'h00010,
		S_SRCH_B = 19'h00020,
		S_LD_A   = 19'h00040,
		S_LD_B   = 19'h00080,
		S_COEF   = 19'h00100,
		S_NX     = 19'h00200,
		S_NCHK   = 19'h00400,
		S_NS     = 19'h00800,
		S_NDCHK  = 19'h01000,
		S_NDIV   = 19'h02000,
		S_NUPD   = 19'h04000,
		S_BSET   = 19'h08000,
		S_BX     = 19'h10000,
		S_BCHK   = 19'h20000,
		S_YEV    = 19'h40000
	} state_t;

	typedef struct packed {
		logic signed [CW-1:0] a;
		logic signed [CW-1:0] a3;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] b2;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] d;
	} coef_t;

	function automatic coef_t mk_coef(input logic signed [COORD_W-1:0] p0,
		input logic signed [COORD_W-1:0] p1, input logic signed [COORD_W-1:0] p2,
		input logic signed [COORD_W-1:0] p3);
		logic signed [CW-1:0] s0, s1, s2, s3, m, n, o;
		coef_t k;
		s0 = CW'(p0);
		s1 = CW'(p1);
		s2 = CW'(p2);
		s3 = CW'(p3);
		m = s2 - s1;
		n = s2 - (s1 <<< 1) + s0;
		o = s1 - s0;
		k.a  = s3 - ((m <<< 1) + m) - s0;
		k.a3 = (k.a <<< 1) + k.a;
		k.b  = (n <<< 1) + n;
		k.b2 = k.b <<< 1;
		k.c  = (o <<< 1) + o;
		k.d  = s0;
		return k;
	endfunction

	state_t                       state_q;
	logic                         pend_out_q;
	logic [CNT_W-1:0]             seg_count_q;
	logic [1:0]                   step_q;
	logic [NI_W-1:0]              ni_q;
	logic [BI_W-1:0]              bi_q;
	logic [SEG_W-1:0]             idx_q;
	logic [SEG_W-1:0]             sel_q;
	logic [1:0]                   lk_q;
	status_t                      pend_st_q;
	logic                         out_valid_q;

	logic signed [COORD_W-1:0]    q_q;
	logic                         bad_q;
	logic signed [COORD_W-1:0]    px_q [4];
	logic signed [COORD_W-1:0]    py_q [4];
	coef_t                        kx_q, ky_q;
	logic signed [TW-1:0]         t_q, t0_q, t1_q;
	logic [E_W-1:0]               e_mag_q;
	logic                         e_neg_q;
	logic                         neg_q;
	logic                         ovf_q;
	logic signed [COORD_W-1:0]    y_q;
	status_t                      stat_q;

	logic                         in_acc, out_acc, wr_en;
	logic [CNT_W-1:0]             cnt_eff;
	logic [SEG_W-1:0]             last_seg;
	logic [ADDR_W-1:0]            raddr;
	logic [PT_W-1:0]              rdata;
	logic signed [COORD_W-1:0]    rd_x, rd_y;
	logic                         mac_en;
	logic                         ns_mode;
	logic                         last_step;
	coef_t                        kk;
	logic signed [ACC_W-1:0]      op_a, addend, acc;
	logic signed [E_W-1:0]        e_n;
	logic [E_W-1:0]               e_mag;
	logic                         conv;
	logic [ACC_W-1:0]             d_mag;
	logic                         d_small;
	logic                         ovf;
	logic [QBITS-1:0]             step_mag;
	logic signed [QBITS:0]        step_s;
	logic signed [QBITS+1:0]      t_diff;
	logic signed [TW-1:0]         t_upd;
	logic signed [TW-1:0]         t0n, t1n, tm;
	logic                         bis_end;
	logic                         out_free;
	logic                         load_out;
	logic signed [COORD_W-1:0]    y_sat;
	div_req_t                     div_req;
	div_rsp_t                     div_rsp;

	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = state_q == S_YEV && pend_out_q && out_free;
	assign wr_en     = in_acc && cmd == CMD_WRITE && segment_index < MAX_SEGMENTS;
	assign cnt_eff   = (seg_count_q > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : seg_count_q;
	assign last_seg  = SEG_W'(cnt_eff - 1'b1);

	always_comb begin
		case (state_q)
			S_CHK_B:  raddr = {last_seg, 2'd3};
			S_SRCH_A: raddr = {idx_q, 2'd3};
			S_LD_A:   raddr = {sel_q, lk_q};
			default:  raddr = '0;
		endcase
	end

	pbz_ram #(
		.WIDTH(PT_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr({segment_index[SEG_W-1:0], point_index}),
		.wdata({point_x, point_y}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_x = $signed(rdata[PT_W-1:COORD_W]);
	assign rd_y = $signed(rdata[COORD_W-1:0]);

	// operand selection for the shared unit: horner steps of x, y or dx/dt
	assign ns_mode   = state_q == S_NS;
	assign kk        = (state_q == S_YEV) ? ky_q : kx_q;
	// the unit holds y once it is formed
	assign mac_en    = state_q == S_NX || state_q == S_NS || state_q == S_BX ||
		(state_q == S_YEV && !pend_out_q);
	assign last_step = ns_mode ? (step_q == 2'd1) : (step_q == 2'd2);

	always_comb begin
		case (step_q)
			2'd0: begin
				op_a   = ns_mode ? ACC_W'(kk.a3) : ACC_W'(kk.a);
				addend = ns_mode ? ACC_W'(kk.b2) : ACC_W'(kk.b);
			end
			2'd1: begin
				op_a   = acc;
				addend = ACC_W'(kk.c);
			end
			default: begin
				op_a   = acc;
				addend = ACC_W'(kk.d);
			end
		endcase
	end

	pbz_mac u_mac (
		.clk   (clk),
		.en    (mac_en),
		.op_a  (op_a),
		.op_t  (t_q),
		.addend(addend),
		.acc   (acc)
	);

	assign e_n     = E_W'(acc) - E_W'(q_q);
	assign e_mag   = e_n[E_W-1] ? E_W'(-e_n) : E_W'(e_n);
	assign conv    = e_mag < EPS_Q;
	assign d_mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
	assign d_small = d_mag < DERIV_MIN;
	// quotient would leave the t range whatever its low bits
	assign ovf     = (E_W + QBITS - FRAC_BITS)'(e_mag_q) >=
		{d_mag, {(QBITS - FRAC_BITS){1'b0}}};

	assign div_req.start = state_q == S_NDCHK && !d_small && !ovf;
	assign div_req.num   = {e_mag_q, {FRAC_BITS{1'b0}}};
	assign div_req.den   = d_mag;

	pbz_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign step_mag = ovf_q ? QBITS'(1) << (QBITS - 1) : div_rsp.quo;
	assign step_s   = neg_q ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
	assign t_diff   = (QBITS + 2)'(t_q) - (QBITS + 2)'(step_s);
	always_comb begin
		if (t_diff > T_LIMIT) begin
			t_upd = TW'(T_LIMIT);
		end else if (t_diff < -T_LIMIT) begin
			t_upd = TW'(-T_LIMIT);
		end else begin
			t_upd = t_diff[TW-1:0];
		end
	end

	// bisection: acc below query moves the low bound up
	assign t0n     = e_n[E_W-1] ? t_q : t0_q;
	assign t1n     = e_n[E_W-1] ? t1_q : t_q;
	assign tm      = t0n + ((t1n - t0n) >>> 1);
	assign bis_end = bi_q == BI_W'(BISECT_STEPS - 1) || !(t0n < t1n);

	always_comb begin
		if (acc > 524287) begin
			y_sat = COORD_W'(524287);
		end else if (acc < -524288) begin
			y_sat = COORD_W'(-524288);
		end else begin
			y_sat = acc[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_out_q  <= 1'b0;
			seg_count_q <= '0;
			step_q      <= '0;
			ni_q        <= '0;
			bi_q        <= '0;
			idx_q       <= '0;
			sel_q       <= '0;
			lk_q        <= '0;
			pend_st_q   <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seg_count_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			if (mac_en) begin
				step_q <= last_step ? 2'd0 : step_q + 2'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && cmd == CMD_EVAL) begin
						if (cnt_eff == '0) begin
							pend_st_q  <= ST_INVALID;
							pend_out_q <= 1'b1;
							state_q    <= S_YEV;
						end else begin
							pend_st_q <= ST_OK;
							state_q   <= S_CHK_A;
						end
					end
				end
				S_CHK_A: state_q <= S_CHK_B;
				S_CHK_B: state_q <= S_CHK_C;
				S_CHK_C: begin
					if (bad_q || rd_x != ONE_Q) begin
						pend_st_q  <= ST_INVALID;
						pend_out_q <= 1'b1;
						state_q    <= S_YEV;
					end else begin
						idx_q   <= '0;
						state_q <= S_SRCH_A;
					end
				end
				S_SRCH_A: state_q <= S_SRCH_B;
				S_SRCH_B: begin
					if (rd_x > q_q) begin
						sel_q   <= idx_q;
						lk_q    <= '0;
						state_q <= S_LD_A;
					end else if (idx_q == last_seg) begin
						sel_q   <= (q_q >= ONE_Q) ? last_seg : '0;
						lk_q    <= '0;
						state_q <= S_LD_A;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SRCH_A;
					end
				end
				S_LD_A: state_q <= S_LD_B;
				S_LD_B: begin
					lk_q    <= lk_q + 2'd1;
					state_q <= (lk_q == 2'd3) ? S_COEF : S_LD_A;
				end
				S_COEF: begin
					ni_q    <= '0;
					state_q <= S_NX;
				end
				S_NX: if (last_step) state_q <= S_NCHK;
				S_NCHK: state_q <= conv ? S_YEV : S_NS;
				S_NS: if (last_step) state_q <= S_NDCHK;
				S_NDCHK: begin
					if (d_small) begin
						state_q <= S_BSET;
					end else if (ovf) begin
						state_q <= S_NUPD;
					end else begin
						state_q <= S_NDIV;
					end
				end
				S_NDIV: if (div_rsp.done) state_q <= S_NUPD;
				S_NUPD: begin
					ni_q    <= ni_q + 1'b1;
					state_q <= (ni_q == NI_W'(NEWTON_STEPS - 1)) ? S_BSET : S_NX;
				end
				S_BSET: begin
					bi_q    <= '0;
					state_q <= (q_q < 0 || q_q > ONE_Q) ? S_YEV : S_BX;
				end
				S_BX: if (last_step) state_q <= S_BCHK;
				S_BCHK: begin
					bi_q <= bi_q + 1'b1;
					if (conv) begin
						state_q <= S_YEV;
					end else if (bis_end) begin
						pend_st_q <= ST_NOCONV;
						state_q   <= S_YEV;
					end else begin
						state_q <= S_BX;
					end
				end
				S_YEV: begin
					// invalid tables skip the curve and only wait for the output slot
					if (pend_out_q) begin
						if (out_free) begin
							pend_out_q <= 1'b0;
							state_q    <= S_IDLE;
						end
					end else if (last_step) begin
						pend_out_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					q_q <= query_x;
				end
			end
			S_CHK_B: bad_q <= rd_x != 0;
			S_LD_B: begin
				px_q[lk_q] <= rd_x;
				py_q[lk_q] <= rd_y;
			end
			S_COEF: begin
				kx_q <= mk_coef(px_q[0], px_q[1], px_q[2], px_q[3]);
				ky_q <= mk_coef(py_q[0], py_q[1], py_q[2], py_q[3]);
				t_q  <= TW'(q_q);
			end
			S_NCHK: begin
				e_mag_q <= e_mag;
				e_neg_q <= e_n[E_W-1];
			end
			S_NDCHK: begin
				neg_q <= e_neg_q ^ acc[ACC_W-1];
				ovf_q <= ovf;
			end
			S_NUPD: t_q <= t_upd;
			S_BSET: begin
				t0_q <= '0;
				t1_q <= TW'(ONE_Q);
				if (q_q < 0) begin
					t_q <= '0;
				end else if (q_q > ONE_Q) begin
					t_q <= TW'(ONE_Q);
				end else begin
					t_q <= TW'(q_q);
				end
			end
			S_BCHK: begin
				if (!conv) begin
					t0_q <= t0n;
					t1_q <= t1n;
					t_q  <= tm;
				end
			end
			S_YEV: begin
				if (pend_out_q && out_free) begin
					y_q    <= (pend_st_q == ST_INVALID) ? '0 : y_sat;
					stat_q <= pend_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign y_value   = y_q;
	assign status    = stat_q;

	always_ff @(posedge clk) begin
		assert property (disable iff (!arst_n) $onehot(state_q))
			else $error("sequencer state not one-hot");
		assert property (disable iff (!arst_n) div_rsp.done |-> state_q == S_NDIV)
			else $error("divider result outside newton update");
		assert property (disable iff (!arst_n)
			$rose(out_valid_q) |-> $past(state_q == S_YEV && pend_out_q))
			else $error("result loaded outside final step");
		assert property (disable iff (!arst_n) out_valid_q && out_stall |=> out_valid_q)
			else $error("held result dropped");
		assert property (disable iff (!arst_n) ni_q <= NEWTON_STEPS && bi_q <= BISECT_STEPS)
			else $error("iteration count out of range");
	end
endmodule

// File: bench/piecewise_cubic_bezier_y_from_x_core_test.sv
// self-checking testbench for the piecewise cubic bezier y-from-x solver
`timescale 1ns / 1ps
module piecewise_cubic_bezier_y_from_x_core_test;
	import pbz_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE      = 400;
	localparam int ITEM_GOAL   = 650;

	typedef struct {
		logic signed [COORD_W-1:0] y;
		status_t                   st;
	} curve_res_t;

	typedef enum {ROW_CFG, ROW_WR, ROW_EV} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int        seg;
		int        pt;
		int        xv;
		int        yv;
		bit        typed;
		int        ty;
		status_t   tst;
	} plan_row_t;

	typedef struct {
		longint a, b, c, d;
	} cubic_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CNT_W-1:0]          cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      cmd;
	logic [3:0]                segment_index;
	logic [1:0]                point_index;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] query_x;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [COORD_W-1:0] y_value;
	logic [1:0]                status;

	// mirror of the point store and the count register
	int         curve_x [STORE_DEPTH];
	int         curve_y [STORE_DEPTH];
	int         seg_count;
	curve_res_t pending_y[$];
	plan_row_t  plan[$];
	int         errors;
	int         beats;
	int         results;
	int         settings;
	int         cycles;
	int         idle_mode;

	piecewise_cubic_bezier_y_from_x_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.segment_index(segment_index), .point_index(point_index),
		.point_x(point_x), .point_y(point_y), .query_x(query_x),
		.out_valid(out_valid), .out_stall(out_stall), .y_value(y_value),
		.status(status)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint fsh(longint v);
		return v >>> FRAC_BITS;
	endfunction

	function automatic longint clamp_t(longint t);
		if (t > T_LIMIT) return T_LIMIT;
		if (t < -T_LIMIT) return -T_LIMIT;
		return t;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat20(longint v);
		if (v > 524287) return 20'sd524287;
		if (v < -524288) return -20'sd524288;
		return v[COORD_W-1:0];
	endfunction

	function automatic cubic_t coeffs(bit use_y, int base);
		cubic_t k;
		longint p0, p1, p2, p3;
		p0 = use_y ? curve_y[base]   : curve_x[base];
		p1 = use_y ? curve_y[base+1] : curve_x[base+1];
		p2 = use_y ? curve_y[base+2] : curve_x[base+2];
		p3 = use_y ? curve_y[base+3] : curve_x[base+3];
		k.a = p3 - 3 * (p2 - p1) - p0;
		k.b = 3 * (p2 - 2 * p1 + p0);
		k.c = 3 * (p1 - p0);
		k.d = p0;
		return k;
	endfunction

	function automatic longint eval_cubic(cubic_t k, longint t);
		longint h;
		h = fsh(k.a * t) + k.b;
		h = fsh(h * t) + k.c;
		return fsh(h * t) + k.d;
	endfunction

	function automatic longint slope_cubic(cubic_t k, longint t);
		longint h;
		h = fsh(3 * k.a * t) + 2 * k.b;
		return fsh(h * t) + k.c;
	endfunction

	function automatic curve_res_t solve_curve_y(longint q);
		curve_res_t r;
		cubic_t kx, ky;
		int cnt, sel, i;
		bit found;
		longint t, t0, t1, e, d;
		cnt = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
		r.st = ST_OK;
		if (cnt == 0 || curve_x[0] != 0 || curve_x[(cnt-1)*4+3] != ONE_Q) begin
			r.y = '0;
			r.st = ST_INVALID;
			return r;
		end
		sel = (q >= ONE_Q) ? cnt - 1 : 0;
		found = 0;
		for (i = 0; i < cnt; i++) begin
			if (!found && curve_x[i*4+3] > q) begin
				sel = i;
				found = 1;
			end
		end
		kx = coeffs(0, sel * 4);
		ky = coeffs(1, sel * 4);
		t = clamp_t(q);
		for (i = 0; i < NEWTON_STEPS; i++) begin
			e = eval_cubic(kx, t) - q;
			if ((e < 0 ? -e : e) < EPS_Q) begin
				r.y = sat20(eval_cubic(ky, t));
				return r;
			end
			d = slope_cubic(kx, t);
			if ((d < 0 ? -d : d) < DERIV_MIN) break;
			t = clamp_t(t - (e * ONE_Q) / d);
		end
		t0 = 0;
		t1 = ONE_Q;
		t = q;
		if (t < t0) begin
			r.y = sat20(eval_cubic(ky, t0));
			return r;
		end
		if (t > t1) begin
			r.y = sat20(eval_cubic(ky, t1));
			return r;
		end
		for (i = 0; i < BISECT_STEPS && t0 < t1; i++) begin
			e = eval_cubic(kx, t);
			if ((e - q < 0 ? q - e : e - q) < EPS_Q) begin
				r.y = sat20(eval_cubic(ky, t));
				return r;
			end
			if (q > e) t0 = t;
			else t1 = t;
			t = t0 + ((t1 - t0) >>> 1);
		end
		r.y = sat20(eval_cubic(ky, t));
		r.st = ST_NOCONV;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	function automatic int send_pct();
		return (idle_mode == 0) ? 34 : (idle_mode == 1) ? 52 : 0;
	endfunction

	// append one row to the directed table
	function automatic void add_row(row_kind_t kind, int seg, int pt, int xv, int yv,
			bit typed, int ty, status_t tst);
		plan_row_t r;
		r = '{kind, seg, pt, xv, yv, typed, ty, tst};
		plan.insert(plan.size(), r);
	endfunction

	// one input beat; typed rows carry their own expectation
	task automatic send(bit is_eval, int seg, int pt, int xv, int yv,
			bit typed, int ty, status_t tst);
		int gap;
		curve_res_t r;
		in_valid      <= 1'b1;
		cmd           <= is_eval ? CMD_EVAL : CMD_WRITE;
		segment_index <= seg[3:0];
		point_index   <= pt[1:0];
		point_x       <= is_eval ? COORD_W'($urandom) : xv[COORD_W-1:0];
		point_y       <= yv[COORD_W-1:0];
		query_x       <= is_eval ? xv[COORD_W-1:0] : COORD_W'($urandom);
		do @(posedge clk); while (in_stall);
		beats++;
		if (is_eval) begin
			r = solve_curve_y(longint'($signed(xv[COORD_W-1:0])));
			if (typed) begin
				r.y = ty[COORD_W-1:0];
				r.st = tst;
			end
			pending_y.insert(pending_y.size(), r);
		end else begin
			curve_x[seg*4+pt] = $signed(xv[COORD_W-1:0]);
			curve_y[seg*4+pt] = $signed(yv[COORD_W-1:0]);
		end
		gap = 0;
		while ($urandom_range(0, 99) < send_pct() && gap < 12) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register write only once the solver has drained
	task automatic write_count(int v);
		in_valid <= 1'b0;
		wait (pending_y.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v[CNT_W-1:0];
		@(posedge clk);
		cfg_we   <= 1'b0;
		seg_count = v;
		settings++;
	endtask

	// monotone-ish curve over [0, 1] with n segments, plus a little noise
	task automatic load_curve(int n, int noise_pct);
		int brk[MAX_SEGMENTS+1];
		int i, p, lo, hi, xv, yv, jit;
		brk[0] = 0;
		brk[n] = ONE_Q;
		jit = ONE_Q / (4 * n);
		for (i = 1; i < n; i++)
			brk[i] = i * ONE_Q / n + $urandom_range(0, 2 * jit) - jit;
		for (i = 0; i < n; i++) begin
			lo = brk[i];
			hi = brk[i+1];
			for (p = 0; p < 4; p++) begin
				xv = (p == 0) ? lo : (p == 3) ? hi : $urandom_range(lo, hi);
				yv = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 1 << 18) - (1 << 17);
				if ($urandom_range(0, 99) < noise_pct) xv = $urandom;
				send(0, i, p, xv, yv, 0, 0, ST_OK);
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= $urandom_range(0, 99) <
			((idle_mode == 0) ? 52 : (idle_mode == 1) ? 34 : 0);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			results++;
			if (pending_y.size() == 0) begin
				$display("unexpected result beat y=%0d status=%0d (cycle %0d)",
					y_value, status, cycles);
				errors++;
			end else begin
				if (y_value !== pending_y[0].y) report("y_value", y_value, pending_y[0].y);
				if (status !== pending_y[0].st) report("status", status, pending_y[0].st);
				void'(pending_y.pop_front());
			end
		end
	end

	initial begin
		int i, n, k, q, evals;
		plan_row_t row;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_WRITE;
		segment_index = '0;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		query_x = '0;
		out_stall = 1'b0;
		errors = 0;
		beats = 0;
		results = 0;
		settings = 0;
		cycles = 0;
		idle_mode = 0;
		seg_count = 0;
		for (i = 0; i < STORE_DEPTH; i++) begin
			curve_x[i] = 0;
			curve_y[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table right after reset
		send(1, 0, 0, 0, 0, 1, 0, ST_INVALID);
		// fill every entry so nothing unwritten is ever read
		load_curve(MAX_SEGMENTS, 0);

		add_row(ROW_EV, 0, 0, 32768, 0, 1, 0, ST_INVALID);
		add_row(ROW_CFG, 0, 0, MAX_SEGMENTS, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 0, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, ONE_Q, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, -524288, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 524287, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 40000, 0, 0, 0, ST_OK);
		add_row(ROW_CFG, 0, 0, 31, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 20000, 0, 0, 0, ST_OK);
		add_row(ROW_WR, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 100, 0, 1, 0, ST_INVALID);
		add_row(ROW_WR, 0, 0, 0, 524287, 0, 0, ST_OK);
		add_row(ROW_WR, 15, 3, ONE_Q - 1, -524288, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 60000, 0, 1, 0, ST_INVALID);
		add_row(ROW_WR, 15, 3, ONE_Q, 524287, 0, 0, ST_OK);
		add_row(ROW_WR, 3, 1, -524288, -524288, 0, 0, ST_OK);
		add_row(ROW_WR, 3, 2, 524287, 524287, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 14000, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, -1, 0, 0, 0, ST_OK);
		add_row(ROW_CFG, 0, 0, 1, 0, 0, 0, ST_OK);
		add_row(ROW_EV, 0, 0, 5000, 0, 1, 0, ST_INVALID);

		foreach (plan[j]) begin
			row = plan[j];
			case (row.kind)
				ROW_CFG: write_count(row.xv);
				ROW_WR:  send(0, row.seg, row.pt, row.xv, row.yv, 0, 0, ST_OK);
				default: send(1, 0, 0, row.xv, 0, row.typed, row.ty, row.tst);
			endcase
		end

		// random phases: fresh curve, fresh count, then queries mixed with occasional writes
		k = 0;
		while (beats < ITEM_GOAL) begin
			idle_mode = (beats < 280) ? 0 : (beats < 520) ? 1 : 2;
			n = (k == 0) ? 1 : (k == 1) ? MAX_SEGMENTS : $urandom_range(1, MAX_SEGMENTS);
			load_curve(n, (k % 4 == 3) ? 20 : 3);
			if (k % 7 == 5) write_count(0);
			else if (n == MAX_SEGMENTS && k % 2 == 0) write_count($urandom_range(17, 31));
			else write_count(n);
			evals = $urandom_range(15, 35);
			for (i = 0; i < evals; i++) begin
				case ($urandom_range(0, 9))
					0:       q = $urandom;
					1, 2:    q = curve_x[$urandom_range(0, n - 1) * 4 + 3];
					default: q = $urandom_range(0, ONE_Q + 4000) - 2000;
				endcase
				if ($urandom_range(0, 19) == 0)
					send(0, $urandom_range(0, 15), $urandom_range(0, 3), $urandom, $urandom,
						0, 0, ST_OK);
				else
					send(1, 0, 0, q, 0, 0, 0, ST_OK);
			end
			k++;
		end

		in_valid <= 1'b0;
		wait (pending_y.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d beats over %0d count settings, checked %0d results",
			beats, settings, results);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
